>>> rtl/mqtt_publish_deframer_unit_assert.svh
// assertion macros for the publish deframer checker
`ifndef MQTT_PUBLISH_DEFRAMER_UNIT_ASSERT_SVH
`define MQTT_PUBLISH_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define MQTTPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqttpd assertion failed");

// next-cycle implication, reset masks the check
`define MQTTPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqttpd assertion failed");

`endif

>>> rtl/mqttpd_pkg.sv
// shared types and constants for the publish deframer
package mqttpd_pkg;

    localparam int BUFFER_BYTES_DEF     = 2048;
    localparam int TOPIC_CAPACITY_DEF   = 64;
    localparam int PAYLOAD_CAPACITY_DEF = 256;

    localparam logic [7:0] HDR_TYPE_MASK = 8'hF0;
    localparam logic [7:0] HDR_PUBLISH   = 8'h30;
    localparam logic [7:0] LEN_DATA_MASK = 8'h7F;
    localparam logic [7:0] LEN_CONT_BIT  = 8'h80;
    localparam logic [2:0] LEN_MAX_GROUPS = 3'd4;

    localparam logic [1:0] ROLE_OTHER   = 2'd0;
    localparam logic [1:0] ROLE_TOPIC   = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_ID_HI   = 3'd5,
        PH_ID_LO   = 3'd6,
        PH_BODY    = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  byte_role;
        logic        ack_request;
        logic [15:0] ack_packet_id;
        logic        frame_done;
        logic        frame_ok;
        logic [5:0]  topic_count;
        logic [7:0]  payload_count;
        logic [1:0]  qos_level;
    } out_item_t;

endpackage

>>> rtl/mqttpd_stream_if.sv
// valid/ready stream channel carrying one payload struct
interface mqttpd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input payload, input ready);
endinterface

>>> rtl/mqtt_publish_deframer_unit.sv
// mqtt publish deframer: input register, one-pass byte parse, result register
// each byte passes the input register, then the result register, before its result transaction
// throughput: one byte per cycle, limited only by the result side taking transactions
// the result register and input register let a new byte enter while a result waits
// reset: asynchronous active low, parser returns to header phase with all counts zero
// the parser also returns to header phase after each byte flagged last
module mqtt_publish_deframer_unit #(
    parameter int BUFFER_BYTES     = mqttpd_pkg::BUFFER_BYTES_DEF,
    parameter int TOPIC_CAPACITY   = mqttpd_pkg::TOPIC_CAPACITY_DEF,
    parameter int PAYLOAD_CAPACITY = mqttpd_pkg::PAYLOAD_CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    mqttpd_stream_if.sink   byte_chan,
    mqttpd_stream_if.source result_chan
);

    localparam int PW  = $clog2(BUFFER_BYTES + 1);
    localparam int TSW = (TOPIC_CAPACITY > 2) ? $clog2(TOPIC_CAPACITY) : 1;
    localparam int PSW = (PAYLOAD_CAPACITY > 2) ? $clog2(PAYLOAD_CAPACITY) : 1;
    localparam logic [PW-1:0]  BUF_LIMIT   = PW'(BUFFER_BYTES);
    localparam logic [TSW-1:0] TOPIC_MAX   = TSW'(TOPIC_CAPACITY - 1);
    localparam logic [PSW-1:0] PAYLOAD_MAX = PSW'(PAYLOAD_CAPACITY - 1);

    // pipeline control
    logic                  s1_valid_reg, s1_valid_next;
    logic [7:0]            s1_byte_reg;
    logic                  s1_last_reg;
    logic                  out_valid_reg, out_valid_next;
    mqttpd_pkg::out_item_t out_item_reg, out_item_next;
    logic                  advance, accept, fire;

    // parser state
    mqttpd_pkg::phase_t phase_reg, phase_next;
    logic [27:0]        acc_reg, acc_next;
    logic [2:0]         grp_reg, grp_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PW-1:0]      rem_reg, rem_next;
    logic [15:0]        tlen_reg, tlen_next;
    logic [TSW-1:0]     tstored_reg, tstored_next;
    logic [PSW-1:0]     pstored_reg, pstored_next;
    logic [1:0]         qos_reg, qos_next;
    logic [7:0]         idhi_reg, idhi_next;
    logic               err_reg, err_next;

    // per-byte working values
    logic [7:0]    b;
    logic [PW-1:0] room;
    logic [27:0]   acc_sum;
    logic [15:0]   tl_full;
    logic [15:0]   tl_dec;
    logic [PW-1:0] rem_dec;
    logic [1:0]    role;
    logic          ack;
    logic [15:0]   ack_id;
    logic          ok;
    logic [31:0]   tcount_wide;
    logic [31:0]   pcount_wide;

    assign advance         = !out_valid_reg || result_chan.ready;
    assign byte_chan.ready = !s1_valid_reg || advance;
    assign accept          = byte_chan.valid && byte_chan.ready;
    assign fire            = s1_valid_reg && advance;

    assign result_chan.valid   = out_valid_reg;
    assign result_chan.payload = out_item_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        b       = s1_byte_reg;
        pos_next = (pos_reg < BUF_LIMIT) ? pos_reg + PW'(1) : pos_reg;
        room    = BUF_LIMIT - pos_next;
        acc_sum = acc_reg + (28'(b & mqttpd_pkg::LEN_DATA_MASK) << (5'd7 * 5'(grp_reg[1:0])));
        tl_full = tlen_reg | 16'(b);
        tl_dec  = tlen_reg - 16'd1;
        rem_dec = rem_reg - PW'(1);

        phase_next   = phase_reg;
        acc_next     = acc_reg;
        grp_next     = grp_reg;
        rem_next     = rem_reg;
        tlen_next    = tlen_reg;
        tstored_next = tstored_reg;
        pstored_next = pstored_reg;
        qos_next     = qos_reg;
        idhi_next    = idhi_reg;
        err_next     = err_reg;
        role         = mqttpd_pkg::ROLE_OTHER;
        ack          = 1'b0;
        ack_id       = 16'd0;

        case (phase_reg)
            mqttpd_pkg::PH_HEADER:
            begin
                qos_next = b[2:1];
                if ((b & mqttpd_pkg::HDR_TYPE_MASK) != mqttpd_pkg::HDR_PUBLISH)
                begin
                    err_next   = 1'b1;
                    phase_next = mqttpd_pkg::PH_BODY;
                    rem_next   = '0;
                end
                else
                begin
                    phase_next = mqttpd_pkg::PH_LENGTH;
                end
            end
            mqttpd_pkg::PH_LENGTH:
            begin
                acc_next = acc_sum;
                grp_next = grp_reg + 3'd1;
                if ((b & mqttpd_pkg::LEN_CONT_BIT) != 8'd0)
                begin
                    if (grp_next >= mqttpd_pkg::LEN_MAX_GROUPS)
                    begin
                        err_next   = 1'b1;
                        phase_next = mqttpd_pkg::PH_BODY;
                        rem_next   = '0;
                    end
                end
                else
                begin
                    // clamp declared length to what the buffer can still hold
                    rem_next   = (acc_sum < 28'(room)) ? PW'(acc_sum) : room;
                    phase_next = mqttpd_pkg::PH_TLEN_HI;
                end
            end
            mqttpd_pkg::PH_TLEN_HI:
            begin
                if (rem_reg < PW'(2))
                begin
                    err_next   = 1'b1;
                    phase_next = mqttpd_pkg::PH_BODY;
                    rem_next   = '0;
                end
                else
                begin
                    tlen_next  = {b, 8'h00};
                    rem_next   = rem_dec;
                    phase_next = mqttpd_pkg::PH_TLEN_LO;
                end
            end
            mqttpd_pkg::PH_TLEN_LO:
            begin
                tlen_next = tl_full;
                rem_next  = rem_dec;
                if (tl_full > 16'(rem_dec))
                begin
                    err_next   = 1'b1;
                    phase_next = mqttpd_pkg::PH_BODY;
                    rem_next   = '0;
                end
                else if (tl_full == 16'd0)
                begin
                    phase_next = (qos_reg != 2'd0) ? mqttpd_pkg::PH_ID_HI
                                                   : mqttpd_pkg::PH_BODY;
                end
                else
                begin
                    phase_next = mqttpd_pkg::PH_TOPIC;
                end
            end
            mqttpd_pkg::PH_TOPIC:
            begin
                rem_next = rem_dec;
                if (tstored_reg < TOPIC_MAX)
                begin
                    tstored_next = tstored_reg + TSW'(1);
                    role         = mqttpd_pkg::ROLE_TOPIC;
                end
                tlen_next = tl_dec;
                if (tl_dec == 16'd0)
                begin
                    phase_next = (qos_reg != 2'd0) ? mqttpd_pkg::PH_ID_HI
                                                   : mqttpd_pkg::PH_BODY;
                end
            end
            mqttpd_pkg::PH_ID_HI:
            begin
                if (rem_reg < PW'(2))
                begin
                    err_next   = 1'b1;
                    phase_next = mqttpd_pkg::PH_BODY;
                    rem_next   = '0;
                end
                else
                begin
                    idhi_next  = b;
                    rem_next   = rem_dec;
                    phase_next = mqttpd_pkg::PH_ID_LO;
                end
            end
            mqttpd_pkg::PH_ID_LO:
            begin
                rem_next   = rem_dec;
                ack        = 1'b1;
                ack_id     = {idhi_reg, b};
                phase_next = mqttpd_pkg::PH_BODY;
            end
            default:
            begin
                if (!err_reg && rem_reg != '0)
                begin
                    rem_next = rem_dec;
                    if (pstored_reg < PAYLOAD_MAX)
                    begin
                        pstored_next = pstored_reg + PSW'(1);
                        role         = mqttpd_pkg::ROLE_PAYLOAD;
                    end
                end
            end
        endcase

        ok          = s1_last_reg && !err_next && (phase_next == mqttpd_pkg::PH_BODY);
        tcount_wide = 32'(tstored_next);
        pcount_wide = 32'(pstored_next);

        out_item_next.byte_out      = b;
        out_item_next.byte_role     = role;
        out_item_next.ack_request   = ack;
        out_item_next.ack_packet_id = ack_id;
        out_item_next.frame_done    = s1_last_reg;
        out_item_next.frame_ok      = ok;
        out_item_next.topic_count   = tcount_wide[5:0];
        out_item_next.payload_count = pcount_wide[7:0];
        out_item_next.qos_level     = qos_next;

        // end of buffer: start over for the next one
        if (s1_last_reg)
        begin
            phase_next   = mqttpd_pkg::PH_HEADER;
            acc_next     = '0;
            grp_next     = '0;
            pos_next     = '0;
            rem_next     = '0;
            tlen_next    = '0;
            tstored_next = '0;
            pstored_next = '0;
            qos_next     = '0;
            idhi_next    = '0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= mqttpd_pkg::PH_HEADER;
            acc_reg       <= '0;
            grp_reg       <= '0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            tlen_reg      <= '0;
            tstored_reg   <= '0;
            pstored_reg   <= '0;
            qos_reg       <= '0;
            idhi_reg      <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                grp_reg     <= grp_next;
                pos_reg     <= pos_next;
                rem_reg     <= rem_next;
                tlen_reg    <= tlen_next;
                tstored_reg <= tstored_next;
                pstored_reg <= pstored_next;
                qos_reg     <= qos_next;
                idhi_reg    <= idhi_next;
                err_reg     <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= byte_chan.payload.data_byte;
            s1_last_reg <= byte_chan.payload.last_byte;
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

>>> rtl/mqttpd_checker.sv
// port-level checks for the publish deframer, bound to the top level
`include "mqtt_publish_deframer_unit_assert.svh"

module mqttpd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_ready,
    input mqttpd_pkg::out_item_t res_item
);

    logic ack_untagged;

    assign ack_untagged = (res_item.byte_role == mqttpd_pkg::ROLE_OTHER);

    // a stalled result transaction keeps its contents
    `MQTTPD_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(res_item))

    // success is only reported on the closing byte of a buffer
    `MQTTPD_ASSERT_SAME(a_ok_on_done, res_valid && res_item.frame_ok, res_item.frame_done)

    // packet id reads zero unless an acknowledge is requested
    `MQTTPD_ASSERT_SAME(a_id_zero, res_valid && !res_item.ack_request, res_item.ack_packet_id == '0)

    // an acknowledge byte is never stored as topic or payload
    `MQTTPD_ASSERT_SAME(a_ack_role, res_valid && res_item.ack_request, ack_untagged)

endmodule

bind mqtt_publish_deframer_unit mqttpd_checker u_mqttpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result_chan.valid),
    .res_ready (result_chan.ready),
    .res_item  (result_chan.payload)
);
